[hdl/cptri_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptri_pkg
// Shared types and constants for the closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cptri_pkg;

  localparam int CoordWidth = 32;
  localparam int MulChunk   = 32;
  localparam int MulLat     = 4;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef enum logic [2:0] {
    RegionVtxA     = 3'd0,
    RegionVtxB     = 3'd1,
    RegionEdgeAb   = 3'd2,
    RegionVtxC     = 3'd3,
    RegionEdgeAc   = 3'd4,
    RegionEdgeBc   = 3'd5,
    RegionInterior = 3'd6
  } region_e;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
  } in_t;

  typedef struct packed {
    coord_t  nearest_x;
    coord_t  nearest_y;
    coord_t  nearest_z;
    region_e region;
    logic    degenerate;
  } out_t;

endpackage

[hdl/cptri_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptri_delay
// Enabled shift line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module cptri_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

[hdl/cptri_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptri_mul
// Signed multiplier, four stages: magnitude, chunk products, sum, sign.
// ----------------------------------------------------------------------------
module cptri_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import cptri_pkg::*;

  localparam int NA   = (AW + MulChunk - 1) / MulChunk;
  localparam int NB   = (BW + MulChunk - 1) / MulChunk;
  localparam int AU   = NA * MulChunk;
  localparam int BU   = NB * MulChunk;
  localparam int SUMW = AU + BU;
  localparam int PW   = AW + BW;

  logic [AW-1:0]           abs_a;
  logic [BW-1:0]           abs_b;
  logic [AU-1:0]           ma_q;
  logic [BU-1:0]           mb_q;
  logic [2:0]              neg_q;
  logic [2*MulChunk-1:0]   pp_q [NA][NB];
  logic [SUMW-1:0]         sum_d, sum_q;
  logic [PW-1:0]           mag;
  logic signed [PW-1:0]    p_d, p_q;

  always_comb begin
    abs_a = a_i[AW-1] ? (~a_i + 1'b1) : a_i;
    abs_b = b_i[BW-1] ? (~b_i + 1'b1) : b_i;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (SUMW'(pp_q[i][j]) << (MulChunk * (i + j)));
      end
    end
  end

  always_comb begin
    mag = sum_q[PW-1:0];
    p_d = neg_q[2] ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q     <= AU'(abs_a);
      mb_q     <= BU'(abs_b);
      neg_q[0] <= a_i[AW-1] ^ b_i[BW-1];
      neg_q[1] <= neg_q[0];
      neg_q[2] <= neg_q[1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ma_q[i*MulChunk +: MulChunk] * mb_q[j*MulChunk +: MulChunk];
        end
      end
      sum_q <= sum_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[hdl/cptri_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptri_div
// Pipelined restoring divider, one quotient bit per stage, round half away
// from zero, offset added to the base corner and saturated.
// ----------------------------------------------------------------------------
module cptri_div #(
  parameter int NW  = 172,
  parameter int DNW = 139,
  parameter int QB  = 36,
  parameter int W   = 32
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [NW-1:0]  num_i,
  input  logic [DNW-1:0]        den_i,
  input  logic signed [W-1:0]   base_i,
  output logic signed [W-1:0]   res_o
);

  localparam int RW = (NW > DNW + QB) ? NW : DNW + QB;
  localparam int SW = ((W > QB + 1) ? W : QB + 1) + 1;

  logic [NW-1:0]         mag;
  logic [RW-1:0]         r_q    [QB+1];
  logic [QB-1:0]         q_q    [QB+1];
  logic [DNW-1:0]        den_q  [QB+1];
  logic                  neg_q  [QB+1];
  logic signed [W-1:0]   base_q [QB+1];
  logic [RW:0]           r2;
  logic                  rnd;
  logic [QB:0]           qr_q;
  logic                  negr_q;
  logic signed [W-1:0]   baser_q;
  logic signed [SW-1:0]  qs, sum_s;
  logic signed [W-1:0]   res_d, res_q;

  always_comb begin
    mag = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
    r2  = {r_q[QB], 1'b0};
    rnd = (r2 >= (RW+1)'(den_q[QB]));
  end

  always_comb begin
    qs = SW'($signed({1'b0, qr_q}));
    if (negr_q) begin
      qs = -qs;
    end
    sum_s = SW'(baser_q) + qs;
    if (sum_s[SW-1:W-1] == {(SW-W+1){sum_s[SW-1]}}) begin
      res_d = sum_s[W-1:0];
    end else if (sum_s[SW-1]) begin
      res_d = {1'b1, {(W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= RW'(mag);
      q_q[0]    <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= num_i[NW-1];
      base_q[0] <= base_i;
      for (int s = 0; s < QB; s++) begin
        if (r_q[s] >= (RW'(den_q[s]) << (QB - 1 - s))) begin
          r_q[s+1] <= r_q[s] - (RW'(den_q[s]) << (QB - 1 - s));
          q_q[s+1] <= q_q[s] | (QB'(1) << (QB - 1 - s));
        end else begin
          r_q[s+1] <= r_q[s];
          q_q[s+1] <= q_q[s];
        end
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        base_q[s+1] <= base_q[s];
      end
      qr_q    <= (QB+1)'(q_q[QB]) + (QB+1)'(rnd);
      negr_q  <= neg_q[QB];
      baser_q <= base_q[QB];
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[hdl/closest_point_on_triangle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Nearest point on a triangle to a query point, Voronoi region tests, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid_i / in_stall_o / in_data_i carries one query point
//  and three corners per transfer; output channel out_valid_o / out_stall_i /
//  out_data_o returns the nearest point, region code and degenerate flag.
//  A transfer happens on a rising edge with valid high and stall low.
//  Results reach out_valid_o through 57 pipeline stages plus the output
//  register. Throughput: one item per cycle while in_stall_o is low.
//  Depth is set by the exact products (each split into 32x32 chunk products
//  over four stages, three in series) and the divider, which resolves one of
//  36 quotient bits per stage.
//  Reset clears every valid bit; no result is pending afterwards.
//  When the receiver stalls, the output register holds its result and one
//  more result lands in a skid register; in_stall_o then rises and the whole
//  pipeline freezes until the skid result moves on. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cptri_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cptri_pkg::out_t out_data_o
);
  import cptri_pkg::*;

  localparam int W      = CoordWidth;
  localparam int DW     = W + 1;
  localparam int MPW    = 2 * DW;
  localparam int PW     = MPW + 2;
  localparam int EW     = PW + 2;
  localparam int VPW    = 2 * PW;
  localparam int VW     = VPW + 1;
  localparam int SSW    = VW + 1;
  localparam int NPW    = SSW + DW;
  localparam int NW     = NPW + 1;
  localparam int DNW    = VW + 2;
  localparam int QB     = W + 4;
  localparam int VecW   = 3 * DW + 3 * W;
  localparam int StDot  = 1 + MulLat + 1;
  localparam int StV    = StDot + MulLat + 1;
  localparam int StSel  = StV + 2;
  localparam int StNum  = StSel + MulLat + 1;
  localparam int DivLat = QB + 3;
  localparam int Lat    = StNum + DivLat;

  logic en;
  logic [Lat:1] vld_q;
  logic out_valid_q, skid_full_q;

  // stage 1: differences
  coord_t p_c [3], a_c [3], b_c [3], c_c [3];
  logic signed [DW-1:0] ab_q [3], ac_q [3], ap_q [3], bp_q [3], cp_q [3], cb_q [3];
  coord_t a_q [3], b_q [3], c_q [3];

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  always_comb begin
    p_c[0] = in_data_i.query_x;    p_c[1] = in_data_i.query_y;    p_c[2] = in_data_i.query_z;
    a_c[0] = in_data_i.corner_a_x; a_c[1] = in_data_i.corner_a_y; a_c[2] = in_data_i.corner_a_z;
    b_c[0] = in_data_i.corner_b_x; b_c[1] = in_data_i.corner_b_y; b_c[2] = in_data_i.corner_b_z;
    c_c[0] = in_data_i.corner_c_x; c_c[1] = in_data_i.corner_c_y; c_c[2] = in_data_i.corner_c_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ab_q[k] <= DW'(b_c[k]) - DW'(a_c[k]);
        ac_q[k] <= DW'(c_c[k]) - DW'(a_c[k]);
        ap_q[k] <= DW'(p_c[k]) - DW'(a_c[k]);
        bp_q[k] <= DW'(p_c[k]) - DW'(b_c[k]);
        cp_q[k] <= DW'(p_c[k]) - DW'(c_c[k]);
        cb_q[k] <= DW'(c_c[k]) - DW'(b_c[k]);
        a_q[k]  <= a_c[k];
        b_q[k]  <= b_c[k];
        c_q[k]  <= c_c[k];
      end
    end
  end

  // dot products d1..d6
  logic signed [DW-1:0]  lv [2][3];
  logic signed [DW-1:0]  rv [3][3];
  logic signed [MPW-1:0] dp [6][3];
  logic signed [PW-1:0]  d_q [6];
  logic signed [PW-1:0]  d11 [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lv[0][k] = ab_q[k];
      lv[1][k] = ac_q[k];
      rv[0][k] = ap_q[k];
      rv[1][k] = bp_q[k];
      rv[2][k] = cp_q[k];
    end
  end

  for (genvar di = 0; di < 6; di++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_lane
      cptri_mul #(.AW(DW), .BW(DW)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (lv[di % 2][k]),
        .b_i   (rv[di / 2][k]),
        .p_o   (dp[di][k])
      );
    end
    cptri_delay #(.WIDTH(PW), .DEPTH(StV - StDot)) u_dly (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (d_q[di]),
      .q_o   (d11[di])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int di = 0; di < 6; di++) begin
        d_q[di] <= PW'(dp[di][0]) + PW'(dp[di][1]) + PW'(dp[di][2]);
      end
    end
  end

  // barycentric determinants
  logic signed [VPW-1:0] vp [6];
  logic signed [VW-1:0]  va_q, vb_q, vc_q;

  cptri_mul #(.AW(PW), .BW(PW)) u_vc0 (.clk_i(clk_i), .en_i(en), .a_i(d_q[0]), .b_i(d_q[3]),
                                       .p_o(vp[0]));
  cptri_mul #(.AW(PW), .BW(PW)) u_vc1 (.clk_i(clk_i), .en_i(en), .a_i(d_q[2]), .b_i(d_q[1]),
                                       .p_o(vp[1]));
  cptri_mul #(.AW(PW), .BW(PW)) u_vb0 (.clk_i(clk_i), .en_i(en), .a_i(d_q[4]), .b_i(d_q[1]),
                                       .p_o(vp[2]));
  cptri_mul #(.AW(PW), .BW(PW)) u_vb1 (.clk_i(clk_i), .en_i(en), .a_i(d_q[0]), .b_i(d_q[5]),
                                       .p_o(vp[3]));
  cptri_mul #(.AW(PW), .BW(PW)) u_va0 (.clk_i(clk_i), .en_i(en), .a_i(d_q[2]), .b_i(d_q[5]),
                                       .p_o(vp[4]));
  cptri_mul #(.AW(PW), .BW(PW)) u_va1 (.clk_i(clk_i), .en_i(en), .a_i(d_q[4]), .b_i(d_q[3]),
                                       .p_o(vp[5]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      vc_q <= VW'(vp[0]) - VW'(vp[1]);
      vb_q <= VW'(vp[2]) - VW'(vp[3]);
      va_q <= VW'(vp[4]) - VW'(vp[5]);
    end
  end

  // region tests and denominators
  logic [5:0]             cond_q;
  logic signed [DNW-1:0]  dint_q;
  logic signed [EW-1:0]   wn_q, den_ab_q, den_ac_q, den_bc_q;
  logic signed [PW-1:0]   d1_q, d2_q;
  logic signed [VW-1:0]   vb12_q, vc12_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cond_q[0] <= (d11[0] <= 0) && (d11[1] <= 0);
      cond_q[1] <= (d11[2] >= 0) && (d11[3] <= d11[2]);
      cond_q[2] <= (vc_q <= 0) && (d11[0] >= 0) && (d11[2] <= 0);
      cond_q[3] <= (d11[5] >= 0) && (d11[4] <= d11[5]);
      cond_q[4] <= (vb_q <= 0) && (d11[1] >= 0) && (d11[5] <= 0);
      cond_q[5] <= (va_q <= 0) && (d11[3] >= d11[2]) && (d11[4] >= d11[5]);
      dint_q    <= DNW'(va_q) + DNW'(vb_q) + DNW'(vc_q);
      wn_q      <= EW'(d11[3]) - EW'(d11[2]);
      den_ab_q  <= EW'(d11[0]) - EW'(d11[2]);
      den_ac_q  <= EW'(d11[1]) - EW'(d11[5]);
      den_bc_q  <= EW'(d11[3]) - EW'(d11[2]) + EW'(d11[4]) - EW'(d11[5]);
      d1_q      <= d11[0];
      d2_q      <= d11[1];
      vb12_q    <= vb_q;
      vc12_q    <= vc_q;
    end
  end

  // vectors and corners aligned with the selection stage
  logic [VecW-1:0]      vec_d [3], vec12 [3];
  logic signed [DW-1:0] ab12 [3], ac12 [3], cb12 [3];
  coord_t               a12 [3], b12 [3], c12 [3];

  for (genvar k = 0; k < 3; k++) begin : g_vec
    assign vec_d[k] = {ab_q[k], ac_q[k], cb_q[k], a_q[k], b_q[k], c_q[k]};
    cptri_delay #(.WIDTH(VecW), .DEPTH(StSel - 2)) u_dly (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (vec_d[k]),
      .q_o   (vec12[k])
    );
    assign ab12[k] = $signed(vec12[k][VecW-1 -: DW]);
    assign ac12[k] = $signed(vec12[k][VecW-DW-1 -: DW]);
    assign cb12[k] = $signed(vec12[k][VecW-2*DW-1 -: DW]);
    assign a12[k]  = $signed(vec12[k][3*W-1 -: W]);
    assign b12[k]  = $signed(vec12[k][2*W-1 -: W]);
    assign c12[k]  = $signed(vec12[k][W-1:0]);
  end

  // operand selection
  region_e               region_d, region_q;
  logic                  degen_d, degen_q;
  logic signed [SSW-1:0] s1_d, s2_d, s1_q, s2_q;
  logic [DNW-1:0]        den_d, den_q;
  logic signed [DW-1:0]  u_q [3], v_q [3];
  coord_t                base_q [3];

  always_comb begin
    region_d = RegionInterior;
    degen_d  = 1'b0;
    s1_d     = '0;
    s2_d     = '0;
    den_d    = DNW'(1);
    priority if (cond_q[0]) begin
      region_d = RegionVtxA;
    end else if (cond_q[1]) begin
      region_d = RegionVtxB;
    end else if (cond_q[2]) begin
      region_d = RegionEdgeAb;
      if (den_ab_q > 0) begin
        s1_d  = SSW'(d1_q);
        den_d = DNW'(den_ab_q);
      end
    end else if (cond_q[3]) begin
      region_d = RegionVtxC;
    end else if (cond_q[4]) begin
      region_d = RegionEdgeAc;
      if (den_ac_q > 0) begin
        s2_d  = SSW'(d2_q);
        den_d = DNW'(den_ac_q);
      end
    end else if (cond_q[5]) begin
      region_d = RegionEdgeBc;
      if (den_bc_q > 0) begin
        s1_d  = SSW'(wn_q);
        den_d = DNW'(den_bc_q);
      end
    end else begin
      region_d = RegionInterior;
      if (dint_q == 0) begin
        degen_d = 1'b1;
      end else if (dint_q < 0) begin
        s1_d  = -SSW'(vb12_q);
        s2_d  = -SSW'(vc12_q);
        den_d = -dint_q;
      end else begin
        s1_d  = SSW'(vb12_q);
        s2_d  = SSW'(vc12_q);
        den_d = dint_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      region_q <= region_d;
      degen_q  <= degen_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      den_q    <= den_d;
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= (region_d == RegionEdgeBc) ? cb12[k] : ab12[k];
        v_q[k] <= ac12[k];
        unique case (region_d)
          RegionVtxB, RegionEdgeBc: base_q[k] <= b12[k];
          RegionVtxC:               base_q[k] <= c12[k];
          default:                  base_q[k] <= a12[k];
        endcase
      end
    end
  end

  // numerators and division
  logic signed [NPW-1:0] np1 [3], np2 [3];
  logic signed [NW-1:0]  num_q [3];
  logic [DNW-1:0]        den18;
  coord_t                base18 [3];
  coord_t                res [3];
  logic [3:0]            tag_out;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= NW'(np1[k]) + NW'(np2[k]);
      end
    end
  end

  cptri_delay #(.WIDTH(DNW), .DEPTH(StNum - StSel)) u_den_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (den_q),
    .q_o   (den18)
  );

  cptri_delay #(.WIDTH(4), .DEPTH(Lat - StSel)) u_tag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({region_q, degen_q}),
    .q_o   (tag_out)
  );

  for (genvar k = 0; k < 3; k++) begin : g_num
    cptri_mul #(.AW(SSW), .BW(DW)) u_mul1 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (s1_q),
      .b_i   (u_q[k]),
      .p_o   (np1[k])
    );
    cptri_mul #(.AW(SSW), .BW(DW)) u_mul2 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (s2_q),
      .b_i   (v_q[k]),
      .p_o   (np2[k])
    );
    cptri_delay #(.WIDTH(W), .DEPTH(StNum - StSel)) u_base_dly (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (base_q[k]),
      .q_o   (base18[k])
    );
    cptri_div #(.NW(NW), .DNW(DNW), .QB(QB), .W(W)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[k]),
      .den_i  (den18),
      .base_i (base18[k]),
      .res_o  (res[k])
    );
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:1], in_valid_i};
    end
  end

  // output register and skid
  out_t tail;
  out_t out_q, skid_q;
  logic out_take;

  always_comb begin
    tail.nearest_x  = res[0];
    tail.nearest_y  = res[1];
    tail.nearest_z  = res[2];
    tail.region     = region_e'(tag_out[3:1]);
    tail.degenerate = tag_out[0];
    out_take        = out_valid_q && !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_full_q) begin
        out_valid_q <= 1'b1;
        skid_full_q <= 1'b0;
      end else begin
        out_valid_q <= vld_q[Lat];
      end
    end else if (vld_q[Lat] && en) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_full_q ? skid_q : tail;
    end else if (vld_q[Lat] && en) begin
      skid_q <= tail;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_catches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && !skid_full_q && vld_q[Lat] |=> skid_full_q)
    else $error("pipeline tail dropped during output stall");

  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while frozen");

  a_degen_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.region == RegionInterior)
    else $error("degenerate flag outside interior region");

endmodule
